@@ rtl/pcode_stack_machine_execute_top_defines.svh @@
// Assertion macros of the p-code machine RTL, used by its top level
`ifndef PCODE_STACK_MACHINE_EXECUTE_TOP_DEFINES_SVH
`define PCODE_STACK_MACHINE_EXECUTE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define PCSM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pcsm assertion failed");
`define PCSM_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("pcsm forbidden condition");
`else
`define PCSM_ASSERT(label, clk, rst, prop)
`define PCSM_NEVER(label, clk, rst, expr)
`endif
`endif

@@ rtl/pcsm_pkg.sv @@
// Types, constants and helpers of the p-code stack machine
`timescale 1ns / 1ps
package pcsm_pkg;
   localparam int STACK_DEPTH = 2048;
   localparam int STACK_AW    = $clog2(STACK_DEPTH);
   localparam int PC_WIDTH    = 16;
   localparam int WORD_W      = 32;
   localparam int ADDR_W      = WORD_W + 2;

   typedef logic signed [ADDR_W-1:0] addr_type;
   typedef logic [WORD_W-1:0]        word_type;

   localparam addr_type PC_LIMIT = addr_type'(1) <<< PC_WIDTH;
   localparam logic [15:0] LEN_RESET = 16'd1024;
   localparam logic [7:0] GLOBAL_LEVEL = 8'd255;

   localparam logic [7:0] OP_LIT = 8'd0;
   localparam logic [7:0] OP_OPR = 8'd1;
   localparam logic [7:0] OP_LOD = 8'd2;
   localparam logic [7:0] OP_STO = 8'd3;
   localparam logic [7:0] OP_CAL = 8'd4;
   localparam logic [7:0] OP_INT = 8'd5;
   localparam logic [7:0] OP_JMP = 8'd6;
   localparam logic [7:0] OP_JPC = 8'd7;
   localparam logic [7:0] OP_STA = 8'd8;
   localparam logic [7:0] OP_LDA = 8'd9;

   localparam logic signed [WORD_W-1:0] OPR_RET = 32'sd0;
   localparam logic signed [WORD_W-1:0] OPR_NEG = 32'sd1;
   localparam logic signed [WORD_W-1:0] OPR_ADD = 32'sd2;
   localparam logic signed [WORD_W-1:0] OPR_SUB = 32'sd3;
   localparam logic signed [WORD_W-1:0] OPR_MUL = 32'sd4;
   localparam logic signed [WORD_W-1:0] OPR_DIV = 32'sd5;
   localparam logic signed [WORD_W-1:0] OPR_ODD = 32'sd6;
   localparam logic signed [WORD_W-1:0] OPR_EQ  = 32'sd8;
   localparam logic signed [WORD_W-1:0] OPR_NE  = 32'sd9;
   localparam logic signed [WORD_W-1:0] OPR_LT  = 32'sd10;
   localparam logic signed [WORD_W-1:0] OPR_GE  = 32'sd11;
   localparam logic signed [WORD_W-1:0] OPR_GT  = 32'sd12;
   localparam logic signed [WORD_W-1:0] OPR_LE  = 32'sd13;

   localparam logic signed [WORD_W-1:0] BI_PRINT   = 32'sh00FFFFFF;
   localparam logic signed [WORD_W-1:0] BI_PRINTLN = 32'sh01000000;
   localparam logic signed [WORD_W-1:0] BI_SCAN    = 32'sh01000003;

   localparam logic [2:0] ST_RUN     = 3'd0;
   localparam logic [2:0] ST_HALT    = 3'd1;
   localparam logic [2:0] ST_BADOP   = 3'd2;
   localparam logic [2:0] ST_PCRANGE = 3'd3;
   localparam logic [2:0] ST_STACK   = 3'd4;
   localparam logic [2:0] ST_DIVZERO = 3'd5;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_READ, S_READ_WAIT, S_WALK_INIT, S_WALK,
      S_WALK_WAIT, S_IND, S_IND_WAIT, S_EXEC, S_DIV, S_CHECK, S_WRITE, S_RESP
   } state_type;

   typedef struct packed {
      logic       clear;
      logic       load;
      logic       skip;
      logic       rd_issue;
      logic       rd_cap;
      logic       walk_init;
      logic       walk_issue;
      logic       walk_cap;
      logic       ind_issue;
      logic       ind_cap;
      logic       exec;
      logic       div_start;
      logic       div_cap;
      logic       check;
      logic       wr;
      logic [1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic       clear_done;
      logic [1:0] n_reads;
      logic [1:0] n_writes;
      logic       walk_done;
      logic       need_ind;
      logic       is_div;
      logic       div_done;
      logic       fault;
      logic       halt;
   } stat_type;

   function automatic logic in_stack(addr_type a);
      return (a >= 0) && (a < addr_type'(STACK_DEPTH));
   endfunction

   function automatic addr_type sext(word_type w);
      return addr_type'($signed(w));
   endfunction
endpackage

@@ rtl/pcode_stack_machine_execute_top.sv @@
// Top level of the PL/0 p-code execution engine
`timescale 1ns / 1ps
`include "pcode_stack_machine_execute_top_defines.svh"
// Executes one p-code instruction per request transaction and answers one
// response transaction with the next pc, a status and an optional number
// print. After reset the 2048-word stack is swept to zero, during which
// req_stall stays high (csr writes are always taken). An instruction reads
// up to 3 stack operands, walks static levels, may do an indirect load and
// writes up to 3 stack words, all through the stack memory with registered
// read data; a divide runs the one-bit-per-cycle divider, which is skipped
// on a zero divisor. Once an error or a self-loop halt is reported, every
// later instruction answers status halted.
module pcode_stack_machine_execute_top import pcsm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_opcode,
   input  logic [7:0]               req_level,
   input  logic signed [WORD_W-1:0] req_operand,
   input  logic signed [WORD_W-1:0] req_scan_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [15:0]              rsp_next_pc,
   output logic [2:0]               rsp_status,
   output logic                     rsp_print_valid,
   output logic signed [WORD_W-1:0] rsp_print_value,
   output logic                     rsp_print_newline,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [15:0]              csr_program_length
);
   cmd_type  cmd;
   stat_type stat;
   word_type print_value;

   assign csr_ready = 1'b1;

   pcsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pcsm_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_opcode         (req_opcode),
      .req_level          (req_level),
      .req_operand        (req_operand),
      .req_scan_value     (req_scan_value),
      .csr_write          (csr_valid && csr_ready),
      .csr_program_length (csr_program_length),
      .cmd                (cmd),
      .stat               (stat),
      .next_pc            (rsp_next_pc),
      .status             (rsp_status),
      .print_valid        (rsp_print_valid),
      .print_value        (print_value),
      .print_newline      (rsp_print_newline)
   );

   assign rsp_print_value = $signed(print_value);

   `PCSM_NEVER(a_no_rsp_while_taking, clock, reset, !req_stall && rsp_valid)
   `PCSM_ASSERT(a_print_only_ok, clock, reset, rsp_valid && rsp_print_valid |-> rsp_status == ST_RUN || rsp_status == ST_HALT)
   `PCSM_ASSERT(a_newline_has_print, clock, reset, rsp_valid && rsp_print_newline |-> rsp_print_valid)
endmodule

@@ rtl/pcsm_div.sv @@
// Radix-2 signed divider, truncating, one quotient bit per cycle
`timescale 1ns / 1ps
module pcsm_div import pcsm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  word_type dividend,
   input  word_type divisor,
   output logic     done,
   output word_type quotient
);
   localparam int CW = $clog2(WORD_W + 1);

   logic          busy_ff, done_ff, neg_ff;
   logic [CW-1:0] cnt_ff;
   word_type      q_ff, rem_ff, den_ff;
   logic [WORD_W:0] rem2;
   logic          ge;

   assign rem2 = {rem_ff, q_ff[WORD_W-1]};
   assign ge   = rem2 >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend[WORD_W-1] ? word_type'(-dividend) : dividend;
         den_ff <= divisor[WORD_W-1] ? word_type'(-divisor) : divisor;
         rem_ff <= '0;
         cnt_ff <= CW'(WORD_W);
         neg_ff <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
      end else if (busy_ff) begin
         rem_ff <= ge ? word_type'(rem2 - {1'b0, den_ff}) : rem2[WORD_W-1:0];
         q_ff   <= {q_ff[WORD_W-2:0], ge};
         cnt_ff <= cnt_ff - CW'(1);
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? word_type'(-q_ff) : q_ff;
endmodule

@@ rtl/pcsm_ctrl.sv @@
// Sequencer of the p-code machine: clear, reads, level walk, indirect load, execute, divide, check, writes
`timescale 1ns / 1ps
module pcsm_ctrl import pcsm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   input  stat_type stat,
   output cmd_type  cmd
);
   state_type  state_ff, state_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       stopped_ff, stopped_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         cnt_ff     <= '0;
         stopped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         stopped_ff <= stopped_in;
      end
   end

   always_comb begin
      cmd        = '0;
      cmd.idx    = cnt_ff;
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      stopped_in = stopped_ff;
      req_stall  = 1'b1;
      rsp_valid  = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (stopped_ff) begin
                  cmd.skip = 1'b1;
                  state_in = S_RESP;
               end else begin
                  cmd.load = 1'b1;
                  state_in = S_DECODE;
               end
            end
         end
         S_DECODE: begin
            cnt_in   = '0;
            state_in = (stat.n_reads != 2'd0) ? S_READ : S_WALK_INIT;
         end
         S_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_READ_WAIT;
         end
         S_READ_WAIT: begin
            cmd.rd_cap = 1'b1;
            if (2'(cnt_ff + 2'd1) == stat.n_reads) begin
               state_in = S_WALK_INIT;
            end else begin
               cnt_in   = 2'(cnt_ff + 2'd1);
               state_in = S_READ;
            end
         end
         S_WALK_INIT: begin
            cmd.walk_init = 1'b1;
            state_in      = S_WALK;
         end
         S_WALK: begin
            if (stat.walk_done) begin
               state_in = stat.need_ind ? S_IND : S_EXEC;
            end else begin
               cmd.walk_issue = 1'b1;
               state_in       = S_WALK_WAIT;
            end
         end
         S_WALK_WAIT: begin
            cmd.walk_cap = 1'b1;
            state_in     = S_WALK;
         end
         S_IND: begin
            cmd.ind_issue = 1'b1;
            state_in      = S_IND_WAIT;
         end
         S_IND_WAIT: begin
            cmd.ind_cap = 1'b1;
            state_in    = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (stat.is_div) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_DIV: begin
            if (stat.div_done) begin
               cmd.div_cap = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            cnt_in    = '0;
            if (stat.fault || stat.halt) stopped_in = 1'b1;
            state_in = (!stat.fault && stat.n_writes != 2'd0) ? S_WRITE : S_RESP;
         end
         S_WRITE: begin
            cmd.wr = 1'b1;
            if (2'(cnt_ff + 2'd1) == stat.n_writes) begin
               state_in = S_RESP;
            end else begin
               cnt_in = 2'(cnt_ff + 2'd1);
            end
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

@@ rtl/pcsm_datapath.sv @@
// Datapath of the p-code machine: registers, stack memory, ALU, divider, result check
`timescale 1ns / 1ps
module pcsm_datapath import pcsm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [7:0]               req_opcode,
   input  logic [7:0]               req_level,
   input  logic signed [WORD_W-1:0] req_operand,
   input  logic signed [WORD_W-1:0] req_scan_value,
   input  logic                     csr_write,
   input  logic [15:0]              csr_program_length,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   output logic [15:0]              next_pc,
   output logic [2:0]               status,
   output logic                     print_valid,
   output word_type                 print_value,
   output logic                     print_newline
);
   word_type mem [STACK_DEPTH];

   logic [15:0]               len_ff;
   logic [PC_WIDTH-1:0]       pc_ff;
   logic [STACK_AW-1:0]       fb_ff, top_ff, clr_ff;
   logic [7:0]                op_ff, lev_ff, walk_cnt_ff;
   logic signed [WORD_W-1:0]  arg_ff;
   word_type                  scan_ff, ind_ff, rdata_ff, pval_ff, pval_out_ff;
   word_type                  r_ff [3];
   word_type                  wv_ff [3];
   addr_type                  wa_ff [3];
   addr_type                  ba_ff, t_ff, nb_ff, p_ff;
   logic                      sfault_ff, div0_ff, pv_ff, pnl_ff, pv_out_ff, pnl_out_ff;
   logic [2:0]                status_ff;

   addr_type   t0, nb0, p0, argx, ind_addr, rd_a;
   addr_type   rd_addr [3];
   logic [1:0] n_reads, n_writes;
   logic       need_walk, walk_stack, need_ind, bad_op, is_div;
   logic       cal_norm, cal_print, cal_scan, opr_bin;
   logic [7:0] wl;
   word_type   prod, alu, quotient;
   logic       div_done;
   addr_type   e_t, e_nb, e_p;
   addr_type   e_wa [3];
   word_type   e_wv [3];
   logic       e_pv, e_pnl;
   word_type   e_pval;
   logic       wr_bad, p_bad, halt, mem_we;
   logic [2:0] fault_code;
   logic [STACK_AW-1:0] mem_wa;
   word_type   mem_wd;

   assign t0   = addr_type'(top_ff);
   assign nb0  = addr_type'(fb_ff);
   assign p0   = addr_type'(pc_ff) + 1;
   assign argx = addr_type'(arg_ff);

   assign opr_bin   = (arg_ff >= OPR_ADD && arg_ff <= OPR_DIV) ||
                      (arg_ff >= OPR_EQ && arg_ff <= OPR_LE);
   assign cal_norm  = arg_ff < BI_PRINT;
   assign cal_print = arg_ff == BI_PRINT || arg_ff == BI_PRINTLN;
   assign cal_scan  = arg_ff == BI_SCAN;
   assign is_div    = op_ff == OP_OPR && arg_ff == OPR_DIV;

   always_comb begin
      n_reads    = 2'd0;
      n_writes   = 2'd0;
      need_walk  = 1'b0;
      walk_stack = 1'b0;
      need_ind   = 1'b0;
      bad_op     = 1'b0;
      rd_addr[0] = t0;
      rd_addr[1] = t0;
      rd_addr[2] = t0;
      case (op_ff)
         OP_LIT: n_writes = 2'd1;
         OP_OPR: begin
            if (arg_ff == OPR_RET) begin
               n_reads    = 2'd2;
               rd_addr[0] = nb0 + 2;
               rd_addr[1] = nb0 + 1;
            end else if (arg_ff == OPR_NEG || arg_ff == OPR_ODD) begin
               n_reads  = 2'd1;
               n_writes = 2'd1;
            end else if (opr_bin) begin
               n_reads    = 2'd2;
               rd_addr[0] = t0 - 1;
               n_writes   = 2'd1;
            end
         end
         OP_LOD: begin
            need_walk = 1'b1;
            need_ind  = 1'b1;
            n_writes  = 2'd1;
         end
         OP_STO: begin
            n_reads   = 2'd1;
            need_walk = 1'b1;
            n_writes  = 2'd1;
         end
         OP_CAL: begin
            if (cal_norm) begin
               need_walk = 1'b1;
               n_writes  = 2'd3;
            end else if (cal_print) begin
               n_reads = 2'd1;
            end else if (cal_scan) begin
               n_writes = 2'd1;
            end
         end
         OP_INT, OP_JMP: ;
         OP_JPC: n_reads = 2'd1;
         OP_STA: begin
            n_reads    = 2'd3;
            rd_addr[1] = t0 - 1;
            rd_addr[2] = t0 - 2;
            need_walk  = 1'b1;
            walk_stack = 1'b1;
            n_writes   = 2'd1;
         end
         OP_LDA: begin
            n_reads    = 2'd2;
            rd_addr[1] = t0 - 1;
            need_walk  = 1'b1;
            walk_stack = 1'b1;
            need_ind   = 1'b1;
            n_writes   = 2'd1;
         end
         default: bad_op = 1'b1;
      endcase
   end

   assign wl       = walk_stack ? r_ff[1][7:0] : lev_ff;
   assign ind_addr = ba_ff + ((op_ff == OP_LDA) ? sext(r_ff[0]) : argx);

   always_comb begin
      if (cmd.walk_issue)     rd_a = ba_ff;
      else if (cmd.ind_issue) rd_a = ind_addr;
      else                    rd_a = rd_addr[cmd.idx];
   end

   assign mem_we = cmd.clear || cmd.wr;
   assign mem_wa = cmd.clear ? clr_ff : wa_ff[cmd.idx][STACK_AW-1:0];
   assign mem_wd = cmd.clear ? '0 : wv_ff[cmd.idx];

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rdata_ff <= mem[rd_a[STACK_AW-1:0]];
   end

   assign prod = word_type'(r_ff[0] * r_ff[1]);

   always_comb begin
      case (arg_ff)
         OPR_ADD: alu = word_type'(r_ff[0] + r_ff[1]);
         OPR_SUB: alu = word_type'(r_ff[0] - r_ff[1]);
         OPR_MUL: alu = prod;
         OPR_EQ:  alu = word_type'(r_ff[0] == r_ff[1]);
         OPR_NE:  alu = word_type'(r_ff[0] != r_ff[1]);
         OPR_LT:  alu = word_type'($signed(r_ff[0]) < $signed(r_ff[1]));
         OPR_GE:  alu = word_type'($signed(r_ff[0]) >= $signed(r_ff[1]));
         OPR_GT:  alu = word_type'($signed(r_ff[0]) > $signed(r_ff[1]));
         OPR_LE:  alu = word_type'($signed(r_ff[0]) <= $signed(r_ff[1]));
         default: alu = '0;
      endcase
   end

   always_comb begin
      e_t    = t0;
      e_nb   = nb0;
      e_p    = p0;
      e_wa[0] = t0;
      e_wa[1] = t0;
      e_wa[2] = t0;
      e_wv[0] = '0;
      e_wv[1] = '0;
      e_wv[2] = '0;
      e_pv   = 1'b0;
      e_pnl  = 1'b0;
      e_pval = '0;
      case (op_ff)
         OP_LIT: begin
            e_t     = t0 + 1;
            e_wa[0] = t0 + 1;
            e_wv[0] = word_type'(arg_ff);
         end
         OP_OPR: begin
            if (arg_ff == OPR_RET) begin
               e_t  = nb0 - 1;
               e_p  = sext(r_ff[0]);
               e_nb = sext(r_ff[1]);
            end else if (arg_ff == OPR_NEG) begin
               e_wv[0] = word_type'(-r_ff[0]);
            end else if (arg_ff == OPR_ODD) begin
               e_wv[0] = {{(WORD_W-1){1'b0}}, r_ff[0][0]};
            end else if (opr_bin) begin
               e_t     = t0 - 1;
               e_wa[0] = t0 - 1;
               e_wv[0] = alu;
            end
         end
         OP_LOD: begin
            e_t     = t0 + 1;
            e_wa[0] = t0 + 1;
            e_wv[0] = ind_ff;
         end
         OP_STO: begin
            e_t     = t0 - 1;
            e_wa[0] = ba_ff + argx;
            e_wv[0] = r_ff[0];
         end
         OP_CAL: begin
            if (cal_norm) begin
               e_wa[0] = t0 + 1;
               e_wv[0] = word_type'(ba_ff);
               e_wa[1] = t0 + 2;
               e_wv[1] = word_type'(nb0);
               e_wa[2] = t0 + 3;
               e_wv[2] = word_type'(p0);
               e_nb    = t0 + 1;
               e_p     = argx;
            end else if (cal_print) begin
               e_pv   = 1'b1;
               e_pval = r_ff[0];
               e_pnl  = arg_ff == BI_PRINTLN;
            end else if (cal_scan) begin
               e_wa[0] = nb0 + 3;
               e_wv[0] = scan_ff;
            end
         end
         OP_INT: e_t = t0 + argx;
         OP_JMP: e_p = argx;
         OP_JPC: begin
            if (r_ff[0] == '0) e_p = argx;
            e_t = t0 - 1;
         end
         OP_STA: begin
            e_t     = t0 - 3;
            e_wa[0] = ba_ff + sext(r_ff[0]);
            e_wv[0] = r_ff[2];
         end
         OP_LDA: begin
            e_t     = t0 - 1;
            e_wa[0] = t0 - 1;
            e_wv[0] = ind_ff;
         end
         default: ;
      endcase
   end

   pcsm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start && r_ff[1] != '0),
      .dividend (r_ff[0]),
      .divisor  (r_ff[1]),
      .done     (div_done),
      .quotient (quotient)
   );

   assign wr_bad = (n_writes >= 2'd1 && !in_stack(wa_ff[0])) ||
                   (n_writes >= 2'd2 && !in_stack(wa_ff[1])) ||
                   (n_writes == 2'd3 && !in_stack(wa_ff[2]));
   assign p_bad  = p_ff < 0 || p_ff >= addr_type'(len_ff) || p_ff >= PC_LIMIT;

   always_comb begin
      if (bad_op)                 fault_code = ST_BADOP;
      else if (sfault_ff)         fault_code = ST_STACK;
      else if (is_div && div0_ff) fault_code = ST_DIVZERO;
      else if (wr_bad)            fault_code = ST_STACK;
      else if (p_bad)             fault_code = ST_PCRANGE;
      else if (!in_stack(t_ff) || !in_stack(nb_ff)) fault_code = ST_STACK;
      else                        fault_code = ST_RUN;
   end

   assign halt = fault_code == ST_RUN && p_ff == addr_type'(pc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_RESET;
         pc_ff  <= '0;
         fb_ff  <= '0;
         top_ff <= '0;
         clr_ff <= '0;
      end else begin
         if (csr_write) len_ff <= csr_program_length;
         if (cmd.clear) clr_ff <= clr_ff + STACK_AW'(1);
         if (cmd.check && fault_code == ST_RUN) begin
            pc_ff  <= p_ff[PC_WIDTH-1:0];
            top_ff <= t_ff[STACK_AW-1:0];
            fb_ff  <= nb_ff[STACK_AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_opcode;
         lev_ff    <= req_level;
         arg_ff    <= req_operand;
         scan_ff   <= word_type'(req_scan_value);
         sfault_ff <= 1'b0;
      end else if ((cmd.rd_issue || cmd.walk_issue || cmd.ind_issue) && !in_stack(rd_a)) begin
         sfault_ff <= 1'b1;
      end
      if (cmd.rd_cap) r_ff[cmd.idx] <= rdata_ff;
      if (cmd.walk_init) begin
         ba_ff       <= (wl == GLOBAL_LEVEL) ? '0 : nb0;
         walk_cnt_ff <= (need_walk && wl != GLOBAL_LEVEL) ? wl : 8'd0;
      end else if (cmd.walk_cap) begin
         ba_ff       <= sext(rdata_ff);
         walk_cnt_ff <= walk_cnt_ff - 8'd1;
      end
      if (cmd.ind_cap) ind_ff <= rdata_ff;
      if (cmd.exec) begin
         t_ff    <= e_t;
         nb_ff   <= e_nb;
         p_ff    <= e_p;
         wa_ff   <= e_wa;
         wv_ff   <= e_wv;
         pv_ff   <= e_pv;
         pnl_ff  <= e_pnl;
         pval_ff <= e_pval;
         div0_ff <= r_ff[1] == '0;
      end else if (cmd.div_cap && !div0_ff) begin
         wv_ff[0] <= quotient;
      end
      if (cmd.skip) begin
         status_ff   <= ST_HALT;
         pv_out_ff   <= 1'b0;
         pnl_out_ff  <= 1'b0;
         pval_out_ff <= '0;
      end else if (cmd.check) begin
         if (fault_code != ST_RUN) begin
            status_ff   <= fault_code;
            pv_out_ff   <= 1'b0;
            pnl_out_ff  <= 1'b0;
            pval_out_ff <= '0;
         end else begin
            status_ff   <= halt ? ST_HALT : ST_RUN;
            pv_out_ff   <= pv_ff;
            pnl_out_ff  <= pnl_ff;
            pval_out_ff <= pval_ff;
         end
      end
   end

   always_comb begin
      stat            = '0;
      stat.clear_done = clr_ff == STACK_AW'(STACK_DEPTH - 1);
      stat.n_reads    = n_reads;
      stat.n_writes   = n_writes;
      stat.walk_done  = walk_cnt_ff == 8'd0;
      stat.need_ind   = need_ind;
      stat.is_div     = is_div;
      stat.div_done   = div_done || div0_ff;
      stat.fault      = fault_code != ST_RUN;
      stat.halt       = halt;
   end

   assign next_pc       = 16'(pc_ff);
   assign status        = status_ff;
   assign print_valid   = pv_out_ff;
   assign print_value   = pval_out_ff;
   assign print_newline = pnl_out_ff;
endmodule
